// ----- hw/rtl/resm_pkg.sv -----
package resm_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Gain is Q1.16, so unity needs one bit above the fraction.
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_W     = GAIN_BITS + 1;
  localparam int LEVEL_BITS = 4;

  localparam logic [LEVEL_BITS-1:0] MAX_SMOOTHNESS   = LEVEL_BITS'(12);
  localparam logic [LEVEL_BITS-1:0] SMOOTHNESS_RESET = LEVEL_BITS'(4);

  typedef logic [GAIN_W-1:0] gain_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [LEVEL_BITS-1:0] smooth;
  } resm_status_t;

  // 2^(-level/2) in Q1.16, rounded to nearest.
  function automatic gain_t gain_lookup(input logic [LEVEL_BITS-1:0] level);
    gain_t g;
    unique case (level)
      4'd0:    g = 17'd65536;
      4'd1:    g = 17'd46341;
      4'd2:    g = 17'd32768;
      4'd3:    g = 17'd23170;
      4'd4:    g = 17'd16384;
      4'd5:    g = 17'd11585;
      4'd6:    g = 17'd8192;
      4'd7:    g = 17'd5793;
      4'd8:    g = 17'd4096;
      4'd9:    g = 17'd2896;
      4'd10:   g = 17'd2048;
      4'd11:   g = 17'd1448;
      default: g = 17'd1024;
    endcase
    return g;
  endfunction

endpackage

// ----- hw/rtl/resm_update.sv -----
module resm_update #(
  parameter int SAMPLE_BITS   = resm_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = resm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [resm_pkg::LEVEL_BITS-1:0]          cfg_wr_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [SAMPLE_BITS-1:0]                   in_sample,
  output logic                                     avg_valid,
  input  logic                                     avg_ready,
  output logic [SAMPLE_BITS+FRACTION_BITS:0]       avg_value,
  output resm_pkg::resm_status_t                   status
);

  localparam int AW = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam int DW = AW + 1;
  localparam int PW = DW + resm_pkg::GAIN_W + 1;
  localparam int LB = resm_pkg::LEVEL_BITS;

  logic [SAMPLE_BITS-1:0] x_r;
  logic                   xv_r, xv_nxt;
  logic                   av_r, av_nxt;
  logic [AW-1:0]          avg_r, avg_nxt;
  logic [LB-1:0]          smooth_r, smooth_nxt;
  logic [LB-1:0]          level_r, level_nxt;

  logic                   in_take;
  logic                   move;
  logic                   stage2_free;
  logic [LB-1:0]          cfg_sat;
  logic [LB-1:0]          level_use;
  resm_pkg::gain_t        gain;

  logic signed [DW-1:0]   x_scaled;
  logic signed [DW-1:0]   diff;
  logic signed [resm_pkg::GAIN_W:0] gain_s;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   prod_rnd;
  logic signed [PW-1:0]   inc_full;
  logic signed [AW+1:0]   sum;
  logic [2:0]             sum_top;

  assign stage2_free = !av_r || avg_ready;
  assign move        = xv_r && stage2_free;
  assign in_stall    = xv_r && !stage2_free;
  assign in_take     = in_valid && !in_stall;

  assign level_use = (level_r < smooth_r) ? level_r : smooth_r;
  assign gain      = resm_pkg::gain_lookup(level_use);
  assign gain_s    = {1'b0, gain};

  assign x_scaled = {{(DW-SAMPLE_BITS-FRACTION_BITS){x_r[SAMPLE_BITS-1]}}, x_r,
                     {FRACTION_BITS{1'b0}}};
  assign diff     = x_scaled - {avg_r[AW-1], avg_r};
  assign prod     = diff * gain_s;
  assign prod_rnd = prod + (PW'(1) << (resm_pkg::GAIN_BITS - 1));
  assign inc_full = prod_rnd >>> resm_pkg::GAIN_BITS;
  assign sum      = {{2{avg_r[AW-1]}}, avg_r} + inc_full[AW+1:0];
  assign sum_top  = sum[AW+1:AW-1];

  assign cfg_sat = (cfg_wr_data > resm_pkg::MAX_SMOOTHNESS) ?
                   resm_pkg::MAX_SMOOTHNESS : cfg_wr_data;

  always_comb begin
    xv_nxt     = xv_r;
    av_nxt     = av_r;
    avg_nxt    = avg_r;
    smooth_nxt = smooth_r;
    level_nxt  = level_r;

    if (in_take) begin
      xv_nxt = 1'b1;
    end else if (move) begin
      xv_nxt = 1'b0;
    end

    if (move) begin
      av_nxt = 1'b1;
    end else if (avg_ready) begin
      av_nxt = 1'b0;
    end

    if (move) begin
      // The sum cannot really leave the average's range, but it is clamped all the same.
      if (sum_top == 3'b000 || sum_top == 3'b111) begin
        avg_nxt = sum[AW-1:0];
      end else if (sum[AW+1]) begin
        avg_nxt = {1'b1, {(AW-1){1'b0}}};
      end else begin
        avg_nxt = {1'b0, {(AW-1){1'b1}}};
      end
      if (level_r < smooth_r) begin
        level_nxt = level_r + LB'(1);
      end
    end

    if (cfg_wr_en) begin
      smooth_nxt = cfg_sat;
      if (level_r > cfg_sat) begin
        level_nxt = cfg_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r     <= 1'b0;
      av_r     <= 1'b0;
      avg_r    <= '0;
      smooth_r <= resm_pkg::SMOOTHNESS_RESET;
      level_r  <= '0;
    end else begin
      xv_r     <= xv_nxt;
      av_r     <= av_nxt;
      avg_r    <= avg_nxt;
      smooth_r <= smooth_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_sample;
    end
  end

  assign avg_valid     = av_r;
  assign avg_value     = avg_r;
  assign status.level  = level_r;
  assign status.smooth = smooth_r;

endmodule

// ----- hw/rtl/resm_output.sv -----
module resm_output #(
  parameter int SAMPLE_BITS   = resm_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = resm_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               avg_valid,
  output logic                               avg_ready,
  input  logic [SAMPLE_BITS+FRACTION_BITS:0] avg_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [SAMPLE_BITS-1:0]             out_smoothed
);

  localparam int AW = SAMPLE_BITS + FRACTION_BITS + 1;

  logic                   ov_r, ov_nxt;
  logic [SAMPLE_BITS-1:0] res_r;
  logic [SAMPLE_BITS-1:0] res_nxt;
  logic                   take;
  logic [AW:0]            rounded;
  logic [SAMPLE_BITS+1:0] whole;
  logic [2:0]             whole_top;

  assign avg_ready = !ov_r || !out_stall;
  assign take      = avg_valid && avg_ready;

  // Round half up, then keep the integer part.
  assign rounded   = {avg_value[AW-1], avg_value} + ((AW+1)'(1) << (FRACTION_BITS - 1));
  assign whole     = rounded[AW:FRACTION_BITS];
  assign whole_top = whole[SAMPLE_BITS+1:SAMPLE_BITS-1];

  always_comb begin
    if (whole_top == 3'b000 || whole_top == 3'b111) begin
      res_nxt = whole[SAMPLE_BITS-1:0];
    end else if (whole[SAMPLE_BITS+1]) begin
      res_nxt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    if (take) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid    = ov_r;
  assign out_smoothed = res_r;

endmodule

// ----- hw/rtl/ramped_exponential_smoother.sv -----
// Exponential smoother with a warm-up ramp: each sample moves a Q17.16 running
// average by 2^(-level/2) of the distance to it, where the level climbs by one per
// sample from zero after reset up to the smoothness register (0 to 12, values above
// are taken as 12), and each result is the average rounded and saturated to the
// sample width. One sample is taken every clock cycle unless the output stalls; each
// result passes through an input register, the average register (whose combinational
// multiply and add feedback sets that rate) and the output register. Smoothness may
// only be written while no sample is in flight.
module ramped_exponential_smoother #(
  parameter int SAMPLE_BITS   = resm_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = resm_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [resm_pkg::LEVEL_BITS-1:0]   cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [SAMPLE_BITS-1:0]            out_smoothed
);

  logic                               avg_valid;
  logic                               avg_ready;
  logic [SAMPLE_BITS+FRACTION_BITS:0] avg_value;
  resm_pkg::resm_status_t             status;

  resm_update #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .avg_valid  (avg_valid),
    .avg_ready  (avg_ready),
    .avg_value  (avg_value),
    .status     (status)
  );

  resm_output #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_output (
    .clk         (clk),
    .rst_n       (rst_n),
    .avg_valid   (avg_valid),
    .avg_ready   (avg_ready),
    .avg_value   (avg_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_smoothed(out_smoothed)
  );

`ifndef SYNTHESIS
  a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    status.level <= status.smooth)
    else $error("ramp level above smoothness");

  a_smooth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    status.smooth <= resm_pkg::MAX_SMOOTHNESS)
    else $error("smoothness above its maximum");

  a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    avg_valid && !avg_ready |=> avg_valid && $stable(avg_value))
    else $error("average lost or changed while held");

  a_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = resm_pkg::SAMPLE_BITS_DEF;
  localparam int FB = resm_pkg::FRACTION_BITS_DEF;
  localparam int LB = resm_pkg::LEVEL_BITS;
  localparam int GB = resm_pkg::GAIN_BITS;
  localparam int SAMPLE_MAX = (1 << (SB - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SB - 1));
  localparam int LONG_HOLD_CYCLES = 200;

  // Q1.16 gain for each level, 2^(-level/2) rounded to nearest.
  localparam longint GAIN_Q16 [0:12] = '{
    65536, 46341, 32768, 23170, 16384, 11585, 8192,
    5793, 4096, 2896, 2048, 1448, 1024
  };

  logic          clk;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [LB-1:0] cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  logic [SB-1:0] in_sample;
  logic          out_valid;
  logic          out_stall;
  logic [SB-1:0] out_smoothed;

  ramped_exponential_smoother #(
    .SAMPLE_BITS  (SB),
    .FRACTION_BITS(FB)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_smoothed(out_smoothed)
  );

  // Predictor state, mirroring the block after reset.
  longint        avg_q16      = 0;
  logic [LB-1:0] ramp_level   = '0;
  logic [LB-1:0] smooth_level = resm_pkg::SMOOTHNESS_RESET;

  logic [SB-1:0] expected_smoothed [$];
  logic [SB-1:0] want_smoothed;
  int            mismatch_count = 0;
  int            in_gap_pct     = 0;
  int            out_stall_pct  = 0;
  int            out_stall_left = 0;
  int            long_hold_left = 0;
  int            drift_level    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [SB-1:0] predict_smoothed(input logic [SB-1:0] sample);
    longint x, d, dh, dl, gain, inc, lim, r;
    logic [LB-1:0] lvl;
    x    = longint'($signed(sample));
    lvl  = (ramp_level < smooth_level) ? ramp_level : smooth_level;
    if (lvl > resm_pkg::MAX_SMOOTHNESS) lvl = resm_pkg::MAX_SMOOTHNESS;
    gain = GAIN_Q16[lvl];
    d    = (x <<< FB) - avg_q16;
    dh   = d >>> GB;
    dl   = d & ((longint'(1) <<< GB) - 1);
    inc  = dh * gain + ((dl * gain + (longint'(1) <<< (GB - 1))) >>> GB);
    lim  = longint'(1) <<< (SB + FB);
    avg_q16 = avg_q16 + inc;
    if (avg_q16 < -lim) avg_q16 = -lim;
    if (avg_q16 > lim - 1) avg_q16 = lim - 1;
    // The level in use is the one from before this sample; the ramp moves afterwards.
    if (ramp_level < smooth_level) ramp_level = ramp_level + 1'b1;
    r = (avg_q16 + (longint'(1) <<< (FB - 1))) >>> FB;
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    return r[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] random_sample();
    int pick, v;
    pick = $urandom_range(0, 99);
    if (pick < 6) drift_level = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
    if (pick < 35) return SB'($urandom());
    if (pick < 45) begin
      case ($urandom_range(0, 3))
        0: v = SAMPLE_MAX;
        1: v = SAMPLE_MIN;
        2: v = 0;
        default: v = -1;
      endcase
      return v[SB-1:0];
    end
    // Mostly slow movement around a level, so the average settles and rounds finely.
    v = drift_level + int'($urandom_range(0, 64)) - 32;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v[SB-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [SB-1:0] sample);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_smoothed.push_back(predict_smoothed(sample));
  endtask

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
      idle_input($urandom_range(1, 13));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_smoothed.size() != 0) @(posedge clk);
  endtask

  task automatic write_smoothness(input logic [LB-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    smooth_level = (value > resm_pkg::MAX_SMOOTHNESS) ? resm_pkg::MAX_SMOOTHNESS : value;
    if (ramp_level > smooth_level) ramp_level = smooth_level;
  endtask

  // Starting from reset the gain is unity, so the first result equals the sample.
  task automatic test_ramp_from_reset();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
  endtask

  task automatic test_smoothness_limits();
    write_smoothness(4'd15);
    send_sample(16'hAAAA);
    send_sample(16'h7FFF);
    // Lowering the setting below the current ramp pulls the ramp down with it.
    write_smoothness(4'd2);
    send_sample(16'h8000);
    send_sample(16'h1234);
    send_sample(16'hEDCB);
    write_smoothness(4'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    write_smoothness(4'd13);
    send_sample(16'h7FFF);
    send_sample(16'h8001);
    write_smoothness(4'd14);
    send_sample(16'h0FF0);
  endtask

  task automatic test_random_settings();
    logic [LB-1:0] settings [0:13];
    int pct_choice [0:3];
    settings   = '{4'd0, 4'd12, 4'd15, 4'd1, 4'd13, 4'd6, 4'd3,
                   4'd14, 4'd9, 4'd2, 4'd11, 4'd5, 4'd8, 4'd10};
    pct_choice = '{0, 5, 20, 50};
    foreach (settings[i]) begin
      write_smoothness(settings[i]);
      in_gap_pct    = pct_choice[$urandom_range(0, 3)];
      out_stall_pct = pct_choice[$urandom_range(0, 3)];
      repeat (100) begin
        send_sample(random_sample());
        maybe_gap();
      end
    end
  endtask

  // The receiver holds off while samples keep coming, so the pipeline fills and the
  // input stalls; once all results are back, random gaps and stalls follow.
  task automatic test_backpressure();
    write_smoothness(4'd7);
    in_gap_pct     = 0;
    out_stall_pct  = 0;
    long_hold_left = LONG_HOLD_CYCLES;
    repeat (60) send_sample(random_sample());
    drain_results();
    in_gap_pct    = 20;
    out_stall_pct = 20;
    repeat (20) begin
      send_sample(random_sample());
      maybe_gap();
    end
  endtask

  task automatic test_full_rate();
    write_smoothness(4'd4);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    repeat (250) send_sample(random_sample());
  endtask

  // Receiver: random stall bursts, plus the long hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_left > 0) begin
        out_stall <= 1'b1;
        long_hold_left--;
      end else if (out_stall_left > 0) begin
        out_stall <= 1'b1;
        out_stall_left--;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall      <= 1'b1;
        out_stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_smoothed.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected", $signed(out_smoothed)));
      end else begin
        want_smoothed = expected_smoothed.pop_front();
        if (out_smoothed !== want_smoothed)
          report_mismatch($sformatf("smoothed %0d, expected %0d",
                                    $signed(out_smoothed), $signed(want_smoothed)));
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_sample   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ramp_from_reset();
    test_smoothness_limits();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
